// File: sv/bpmf_pkg.sv
package bpmf_pkg;

  localparam int unsigned PAT_BYTES = 16;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 64;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(4);
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 8'd0,
    REG_PATTERN_LOW    = 8'd1,
    REG_PATTERN_HIGH   = 8'd2
  } cfg_reg_e;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

// File: sv/bpmf_if.sv
interface bpmf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       region_end;

  modport source (output valid, output data_byte, output region_end, input ready);
  modport sink   (input valid, input data_byte, input region_end, output ready);
endinterface

interface bpmf_out_if;
  logic        valid;
  logic        ready;
  logic        match_found;
  logic [31:0] match_offset;
  logic        region_done;

  modport source (output valid, output match_found, output match_offset,
                  output region_done, input ready);
  modport sink   (input valid, input match_found, input match_offset,
                  input region_done, output ready);
endinterface

interface bpmf_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/bpmf_cell.sv
module bpmf_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bpmf_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]          data_i,
  input  logic [7:0]          pat_i,
  input  logic                active_i,
  output logic [7:0]          data_o,
  output logic                hit_o
);
  import bpmf_pkg::*;

  logic [7:0] byte_q, byte_d;

  // The compare looks at the byte this cell takes on the current shift.
  assign hit_o  = !active_i || (data_i == pat_i);
  assign data_o = byte_q;

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.clear) begin
      byte_d = '0;
    end else if (ctrl_i.shift) begin
      byte_d = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

endmodule

// File: sv/byte_pattern_match_finder.sv
// Searches a byte stream, cut into regions by region_end, for every occurrence
// of a pattern of 1 to 16 bytes, overlapping ones included, and reports the
// region offset at which each match starts. One item is accepted per clock
// cycle while no result waits at a stalled output: a chain of PATTERN_MAX
// byte cells shifts the window and compares every active cell against its
// pattern byte in the same cycle, and the result appears in the output
// register in the cycle after the item is accepted. An item yields a result
// only when it completes a match or closes a region; the window and byte count
// are cleared after a region's last byte. Config writes are always accepted.
module byte_pattern_match_finder #(
  parameter int unsigned PATTERN_MAX = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  bpmf_in_if.sink    in_i,
  bpmf_cfg_if.sink   cfg_i,
  bpmf_out_if.source out_o
);
  import bpmf_pkg::*;

  logic [LEN_W-1:0]     pat_len_q;
  logic [CFG_DAT_W-1:0] pat_low_q;
  logic [CFG_DAT_W-1:0] pat_high_q;

  logic [7:0] pat_bytes [PAT_BYTES];
  logic [LEN_W-1:0] len_used;
  logic [IDX_W-1:0] len_m1;

  logic [7:0] chain [PATTERN_MAX+1];
  logic [PATTERN_MAX-1:0] hits;
  cell_ctrl_t cell_ctrl;

  logic [CNT_W-1:0] count_q, count_d;
  logic             accept;
  logic             found;
  logic [CNT_W-1:0] offset;

  logic             out_valid_q, out_valid_d;
  logic             out_found_q;
  logic [CNT_W-1:0] out_offset_q;
  logic             out_done_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q  <= LEN_RESET;
      pat_low_q  <= '0;
      pat_high_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_PATTERN_LENGTH: pat_len_q  <= cfg_i.data[LEN_W-1:0];
        REG_PATTERN_LOW:    pat_low_q  <= cfg_i.data;
        REG_PATTERN_HIGH:   pat_high_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      pat_bytes[b]     = pat_low_q[b*8 +: 8];
      pat_bytes[b + 8] = pat_high_q[b*8 +: 8];
    end
  end

  always_comb begin
    len_used = pat_len_q;
    if (pat_len_q == '0) begin
      len_used = LEN_W'(1);
    end else if (pat_len_q > LEN_W'(PATTERN_MAX)) begin
      len_used = LEN_W'(PATTERN_MAX);
    end
  end

  assign len_m1 = IDX_W'(len_used - LEN_W'(1));

  assign accept          = in_i.valid && in_i.ready;
  assign cell_ctrl.shift = accept;
  assign cell_ctrl.clear = accept && in_i.region_end;
  assign chain[0]        = in_i.data_byte;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    localparam logic [IDX_W-1:0] Pos = IDX_W'(k);
    logic [IDX_W-1:0] pat_idx;
    logic             active;

    assign pat_idx = len_m1 - Pos;
    assign active  = (Pos <= len_m1);

    bpmf_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (cell_ctrl),
      .data_i   (chain[k]),
      .pat_i    (pat_bytes[pat_idx]),
      .active_i (active),
      .data_o   (chain[k+1]),
      .hit_o    (hits[k])
    );
  end

  always_comb begin
    found  = (&hits) && (count_q >= CNT_W'(len_m1));
    offset = '0;
    if (found) begin
      if (count_q == COUNT_MAX) begin
        offset = COUNT_MAX - CNT_W'(len_used);
      end else begin
        offset = count_q - CNT_W'(len_m1);
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (accept) begin
      if (in_i.region_end) begin
        count_d = '0;
      end else if (count_q != COUNT_MAX) begin
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  assign in_i.ready = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    if (accept) begin
      out_valid_d = found || in_i.region_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_found_q  <= found;
      out_offset_q <= offset;
      out_done_q   <= in_i.region_end;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.match_found  = out_found_q;
  assign out_o.match_offset = out_offset_q;
  assign out_o.region_done  = out_done_q;

endmodule

// File: test/tb_byte_pattern_match_finder.sv
`timescale 1ns / 100ps

module tb_byte_pattern_match_finder;
  import bpmf_pkg::*;

  localparam int unsigned STALL_PCT    = 24;
  localparam int unsigned PHASE_BYTES  = 85;
  localparam int unsigned NOISE_BYTES  = 150;
  localparam int unsigned IDLE_LIMIT   = 1000;
  localparam logic [7:0]  REG_UNMAPPED = 8'd3;
  localparam logic [7:0]  REG_ALIAS_LO = 8'd129;
  localparam logic [7:0]  REG_ALIAS_HI = 8'd130;

  typedef struct packed {
    logic        found;
    logic [31:0] offset;
    logic        done;
  } match_report_t;

  logic clk = 1'b0;
  logic rst_n;

  bpmf_in_if  in_if ();
  bpmf_cfg_if cfg_if ();
  bpmf_out_if out_if ();

  byte_pattern_match_finder #(
    .PATTERN_MAX(PAT_BYTES)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .out_o (out_if)
  );

  logic [LEN_W-1:0] len_reg = LEN_RESET;
  logic [63:0]      pat_low = '0;
  logic [63:0]      pat_high = '0;
  logic [7:0]       recent_bytes [PAT_BYTES];
  logic [CNT_W-1:0] region_count = '0;
  match_report_t    pending_reports [$];

  int unsigned error_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned idle_cycles = 0;
  bit          gap_free = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    foreach (recent_bytes[i]) recent_bytes[i] = '0;
  end

  function automatic int unsigned used_len();
    if (len_reg == 0) return 1;
    if (len_reg > PAT_BYTES) return PAT_BYTES;
    return int'(len_reg);
  endfunction

  function automatic logic [7:0] pat_byte(input int unsigned k);
    return (k < 8) ? pat_low[8*k +: 8] : pat_high[8*(k-8) +: 8];
  endfunction

  function automatic void search_step(input logic [7:0] b, input logic last);
    int unsigned   len;
    logic          hit;
    match_report_t rep;
    len = used_len();
    for (int i = PAT_BYTES - 1; i > 0; i--) recent_bytes[i] = recent_bytes[i-1];
    recent_bytes[0] = b;
    if (region_count != COUNT_MAX) region_count++;
    hit = (region_count >= len);
    for (int unsigned k = 0; k < len; k++) begin
      if (recent_bytes[k] != pat_byte(len - 1 - k)) hit = 1'b0;
    end
    rep.found  = hit;
    rep.offset = hit ? region_count - CNT_W'(len) : '0;
    rep.done   = last;
    if (last) begin
      foreach (recent_bytes[i]) recent_bytes[i] = '0;
      region_count = '0;
    end
    if (hit || last) pending_reports = {pending_reports, rep};
  endfunction

  function automatic void apply_write(input logic [7:0] idx, input logic [63:0] value);
    case (idx)
      REG_PATTERN_LENGTH: len_reg = value[LEN_W-1:0];
      REG_PATTERN_LOW:    pat_low = value;
      REG_PATTERN_HIGH:   pat_high = value;
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    match_report_t want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: unexpected result, expected none, got found %0b offset %0d done %0b",
                   $time, out_if.match_found, out_if.match_offset, out_if.region_done);
          error_count++;
        end else begin
          want = pending_reports.pop_front();
          if (out_if.match_found !== want.found) begin
            $display("%0t: match_found expected %0b, got %0b",
                     $time, want.found, out_if.match_found);
            error_count++;
          end
          if (out_if.match_offset !== want.offset) begin
            $display("%0t: match_offset expected %0d, got %0d",
                     $time, want.offset, out_if.match_offset);
            error_count++;
          end
          if (out_if.region_done !== want.done) begin
            $display("%0t: region_done expected %0b, got %0b",
                     $time, want.done, out_if.region_done);
            error_count++;
          end
        end
      end
      if (in_if.valid && in_if.ready) search_step(in_if.data_byte, in_if.region_end);
      if (cfg_if.valid && cfg_if.ready) apply_write(cfg_if.index, cfg_if.data);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  always @(negedge clk) begin
    out_if.ready <= gap_free || ($urandom_range(0, 99) >= STALL_PCT);
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!gap_free && $urandom_range(0, 99) < STALL_PCT) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.data_byte  <= b;
    in_if.region_end <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic program_pattern(input logic [LEN_W-1:0] len_code);
    logic [127:0] pat;
    logic [7:0]   sym_a;
    logic [7:0]   sym_b;
    int unsigned  style;
    style = $urandom_range(0, 2);
    sym_a = 8'($urandom);
    sym_b = 8'($urandom);
    for (int k = 0; k < 16; k++) begin
      case (style)
        0:       pat[8*k +: 8] = 8'($urandom);
        1:       pat[8*k +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
        default: pat[8*k +: 8] = sym_a;
      endcase
    end
    write_reg(REG_PATTERN_LENGTH, 64'(len_code));
    write_reg(REG_PATTERN_LOW, pat[63:0]);
    write_reg(REG_PATTERN_HIGH, pat[127:64]);
  endtask

  // Regions are built from whole copies of the pattern, with some
  // truncated copies and filler drawn from the pattern bytes or at random.
  task automatic send_region(input int unsigned n);
    logic [7:0]  seg [$];
    int unsigned len;
    int unsigned start;
    len = used_len();
    while (seg.size() < n) begin
      if ($urandom_range(0, 99) < 40) begin
        start = ($urandom_range(0, 99) < 15) ? $urandom_range(1, len) : 0;
        for (int unsigned k = start; k < len; k++) seg = {seg, pat_byte(k)};
      end else if ($urandom_range(0, 1)) begin
        seg = {seg, pat_byte($urandom_range(0, len - 1))};
      end else begin
        seg = {seg, 8'($urandom)};
      end
    end
    for (int unsigned i = 0; i < n; i++) send_byte(seg[i], i == n - 1);
  endtask

  task automatic test_reset_defaults();
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    repeat (4) send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_drained();
  endtask

  task automatic test_length_limits();
    write_reg(REG_PATTERN_LENGTH, 64'd0);
    write_reg(REG_PATTERN_LOW, 64'h0000_0000_0000_00ff);
    write_reg(REG_PATTERN_HIGH, '0);
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    wait_drained();
    write_reg(REG_PATTERN_LENGTH, 64'd31);
    write_reg(REG_PATTERN_LOW, '1);
    write_reg(REG_PATTERN_HIGH, '1);
    write_reg(REG_UNMAPPED, '0);
    write_reg(REG_ALIAS_LO, '0);
    write_reg(REG_ALIAS_HI, '0);
    for (int i = 0; i < 17; i++) send_byte(8'hff, i == 16);
    wait_drained();
  endtask

  task automatic test_random_regions();
    logic [LEN_W-1:0] len_code;
    int unsigned      phase_start;
    int unsigned      len;
    for (int phase = 0; phase < 10; phase++) begin
      wait_drained();
      case (phase)
        0:       len_code = 5'd1;
        1:       len_code = 5'd16;
        2:       len_code = 5'd0;
        3:       len_code = 5'd31;
        6:       len_code = LEN_W'($urandom_range(17, 31));
        default: len_code = LEN_W'($urandom_range(1, 16));
      endcase
      program_pattern(len_code);
      gap_free = (phase == 5);
      len = used_len();
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        if ($urandom_range(0, 9) == 0) send_region($urandom_range(1, 64));
        else send_region($urandom_range(1, 2 * len + 8));
        if (phase == 4) wait_drained();
      end
    end
    gap_free = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_noise();
    logic [7:0] b;
    program_pattern(LEN_W'($urandom_range(1, 2)));
    for (int i = 0; i < NOISE_BYTES; i++) begin
      b = $urandom_range(0, 1) ? 8'($urandom) : pat_byte($urandom_range(0, used_len() - 1));
      send_byte(b, (i == NOISE_BYTES - 1) || ($urandom_range(0, 99) < 6));
      if (i == NOISE_BYTES / 2) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    in_if.valid      = 1'b0;
    in_if.data_byte  = '0;
    in_if.region_end = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;
    out_if.ready     = 1'b0;
    rst_n            = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    test_length_limits();
    test_random_regions();
    test_random_noise();
    wait_drained();
    repeat (5) @(negedge clk);
    if (error_count == 0 && pending_reports.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
